// ----- hw/rtl/pef_pkg.sv -----
package pef_pkg;

   localparam int MAX_TICKS_DEF   = 16384;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int THR_W       = 15;
   localparam int OUT_TICK_W  = 14;
   localparam int CNT_W       = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int RSP_TDATA_W = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_THR_INDUCTION  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_COLLECTION = 1'd1;

   localparam logic [CNT_W-1:0] PEAKS_SINGLE = 2'd1;
   localparam logic [CNT_W-1:0] PEAKS_MERGED = 2'd2;

   typedef struct packed {
      logic [OUT_TICK_W-1:0] open_tick;
      logic [OUT_TICK_W-1:0] close_tick;
      logic [OUT_TICK_W-1:0] first_peak_tick;
      logic [OUT_TICK_W-1:0] second_peak_tick;
      logic [CNT_W-1:0]      peak_count;
   } result_type;

   // results of one input item; r0 goes out first
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- hw/rtl/pef_front.sv -----
module pef_front #(
   parameter int MAX_TICKS   = pef_pkg::MAX_TICKS_DEF,
   parameter int SAMPLE_BITS = pef_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [pef_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pef_pkg::THR_W-1:0]         csr_data,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [SAMPLE_BITS-1:0]     in_sample,
   input  logic                              in_collection,
   input  logic                              in_wire_end,
   input  pef_pkg::qstat_type                qstat,
   output logic                              push,
   output pef_pkg::pair_type                 push_pair
);

   localparam int TICK_W = $clog2(MAX_TICKS);
   localparam int CMP_W  = ((SAMPLE_BITS > pef_pkg::THR_W) ? SAMPLE_BITS : pef_pkg::THR_W) + 2;

   logic [pef_pkg::THR_W-1:0] thr_ind_ff, thr_col_ff;

   logic signed [SAMPLE_BITS-1:0] older_ff, older_in, newer_ff, newer_in;
   logic signed [SAMPLE_BITS-1:0] held_val_ff, held_val_in;
   logic [TICK_W-1:0] tick_ff, tick_in, last_min_ff, last_min_in;
   logic [TICK_W-1:0] open_start_ff, open_start_in, open_peak_ff, open_peak_in;
   logic [TICK_W-1:0] held_start_ff, held_start_in, held_peak_ff, held_peak_in;
   logic [TICK_W-1:0] held_end_ff, held_end_in;
   logic              open_ff, open_in, held_ff, held_in;

   logic [pef_pkg::THR_W-1:0] thr;
   logic signed [CMP_W-1:0]   cur_x, newer_x, older_x, thr_x, held_x2;
   logic [TICK_W-1:0]         centre;
   logic                      window_ok, is_min, is_max, win_close, last_close, close_ev;
   logic                      merge, res_a, res_b, accept;
   logic [TICK_W-1:0]         cl_start, cl_peak, cl_end;
   logic signed [SAMPLE_BITS-1:0] cl_val;
   pef_pkg::result_type       ra, rb;

   assign in_ready = !qstat.full && !reset;
   assign accept   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ind_ff <= '0;
         thr_col_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pef_pkg::CSR_THR_INDUCTION:  thr_ind_ff <= csr_data;
            pef_pkg::CSR_THR_COLLECTION: thr_col_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      thr       = in_collection ? thr_col_ff : thr_ind_ff;
      cur_x     = CMP_W'(in_sample);
      newer_x   = CMP_W'(newer_ff);
      older_x   = CMP_W'(older_ff);
      thr_x     = signed'(CMP_W'(thr));
      held_x2   = CMP_W'(held_val_ff) <<< 1;
      centre    = tick_ff - TICK_W'(1);
      window_ok = tick_ff >= TICK_W'(2);
      is_min    = window_ok && (newer_x < older_x) && (newer_x < cur_x);
      is_max    = window_ok && !is_min && (newer_x > older_x) && (newer_x > cur_x)
                  && (newer_x > thr_x);

      win_close = is_min && open_ff;
      open_in       = open_ff;
      open_start_in = open_start_ff;
      open_peak_in  = open_peak_ff;
      if (win_close) begin
         open_in = 1'b0;
      end else if (is_max && !open_ff) begin
         open_in       = 1'b1;
         open_start_in = last_min_ff;
         open_peak_in  = centre;
      end
      last_close = in_wire_end && open_in;
      close_ev   = win_close || last_close;
      cl_start   = open_in ? open_start_in : open_start_ff;
      cl_peak    = open_in ? open_peak_in : open_peak_ff;
      cl_end     = win_close ? centre : tick_ff;
      cl_val     = win_close ? newer_ff : in_sample;

      merge = close_ev && held_ff && ({1'b0, cl_start} == {1'b0, held_end_ff} + (TICK_W+1)'(1))
              && (held_x2 > thr_x);

      ra.open_tick        = pef_pkg::OUT_TICK_W'(held_start_ff);
      ra.close_tick       = pef_pkg::OUT_TICK_W'(merge ? cl_end : held_end_ff);
      ra.first_peak_tick  = pef_pkg::OUT_TICK_W'(held_peak_ff);
      ra.second_peak_tick = merge ? pef_pkg::OUT_TICK_W'(cl_peak) : '0;
      ra.peak_count       = merge ? pef_pkg::PEAKS_MERGED : pef_pkg::PEAKS_SINGLE;
      res_a = close_ev && (merge || held_ff);

      held_in       = held_ff;
      held_start_in = held_start_ff;
      held_peak_in  = held_peak_ff;
      held_end_in   = held_end_ff;
      held_val_in   = held_val_ff;
      if (merge) begin
         held_in = 1'b0;
      end else if (close_ev) begin
         held_in       = 1'b1;
         held_start_in = cl_start;
         held_peak_in  = cl_peak;
         held_end_in   = cl_end;
         held_val_in   = cl_val;
      end
      if (last_close) open_in = 1'b0;

      rb.open_tick        = pef_pkg::OUT_TICK_W'(held_start_in);
      rb.close_tick       = pef_pkg::OUT_TICK_W'(held_end_in);
      rb.first_peak_tick  = pef_pkg::OUT_TICK_W'(held_peak_in);
      rb.second_peak_tick = '0;
      rb.peak_count       = pef_pkg::PEAKS_SINGLE;
      res_b = in_wire_end && held_in;

      push_pair.two = res_a && res_b;
      push_pair.r0  = res_a ? ra : rb;
      push_pair.r1  = rb;
      push          = accept && (res_a || res_b);

      older_in    = newer_ff;
      newer_in    = in_sample;
      tick_in     = (tick_ff == TICK_W'(MAX_TICKS - 1)) ? tick_ff : tick_ff + TICK_W'(1);
      last_min_in = last_min_ff;
      if (is_min) last_min_in = open_ff ? tick_ff : centre;

      if (in_wire_end) begin
         older_in      = '0;
         newer_in      = '0;
         tick_in       = '0;
         last_min_in   = '0;
         open_in       = 1'b0;
         open_start_in = '0;
         open_peak_in  = '0;
         held_in       = 1'b0;
         held_start_in = '0;
         held_peak_in  = '0;
         held_end_in   = '0;
         held_val_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff      <= '0;
         newer_ff      <= '0;
         tick_ff       <= '0;
         last_min_ff   <= '0;
         open_ff       <= 1'b0;
         open_start_ff <= '0;
         open_peak_ff  <= '0;
         held_ff       <= 1'b0;
         held_start_ff <= '0;
         held_peak_ff  <= '0;
         held_end_ff   <= '0;
         held_val_ff   <= '0;
      end else if (accept) begin
         older_ff      <= older_in;
         newer_ff      <= newer_in;
         tick_ff       <= tick_in;
         last_min_ff   <= last_min_in;
         open_ff       <= open_in;
         open_start_ff <= open_start_in;
         open_peak_ff  <= open_peak_in;
         held_ff       <= held_in;
         held_start_ff <= held_start_in;
         held_peak_ff  <= held_peak_in;
         held_end_ff   <= held_end_in;
         held_val_ff   <= held_val_in;
      end
   end

endmodule

// ----- hw/rtl/pef_queue.sv -----
module pef_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pef_pkg::pair_type  push_pair,
   input  logic               pop,
   output pef_pkg::pair_type  head,
   output pef_pkg::qstat_type qstat
);

   pef_pkg::pair_type store_ff [pef_pkg::QUEUE_DEPTH];

   logic [pef_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [pef_pkg::QPTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + pef_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + pef_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (pef_pkg::QPTR_W+1)'(push) - (pef_pkg::QPTR_W+1)'(pop);
      qstat.full  = cnt_ff == (pef_pkg::QPTR_W+1)'(pef_pkg::QUEUE_DEPTH);
      qstat.empty = cnt_ff == '0;
      head        = store_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= push_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/pef_back.sv -----
module pef_back (
   input  logic                                clock,
   input  logic                                reset,
   input  pef_pkg::qstat_type                  qstat,
   input  pef_pkg::pair_type                   head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pef_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   logic                sub_ff, sub_in;
   logic                at_last, beat;
   pef_pkg::result_type cur;

   always_comb begin
      cur        = sub_ff ? head.r1 : head.r0;
      at_last    = !head.two || sub_ff;
      rsp_tvalid = !qstat.empty;
      beat       = rsp_tvalid && rsp_tready;
      pop        = beat && at_last;
      rsp_tlast  = at_last;
      rsp_tdata  = pef_pkg::RSP_TDATA_W'({cur.peak_count, cur.second_peak_tick,
                                          cur.first_peak_tick, cur.close_tick,
                                          cur.open_tick});
      sub_in     = sub_ff;
      if (beat) sub_in = !at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) sub_ff <= 1'b0;
      else       sub_ff <= sub_in;
   end

endmodule

// ----- hw/rtl/pulse_extremum_finder_unit.sv -----
// An item's results enter the queue on its beat and are sent on rsp from its head.
// Throughput: one item per cycle while the queue is not full; one result beat per
// cycle while rsp_tready is high; a two-result item holds the result side for both
// beats. A four-entry queue after the classifier absorbs bursts and rsp stalls.
// Reset: synchronous, active high; clears thresholds, wire state and the queue.
module pulse_extremum_finder_unit #(
   parameter int MAX_TICKS   = pef_pkg::MAX_TICKS_DEF,
   parameter int SAMPLE_BITS = pef_pkg::SAMPLE_BITS_DEF,
   parameter int REQ_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pef_pkg::THR_W-1:0]          csr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_TDATA_W-1:0]             req_tdata,  // sample_value
   input  logic                               req_tuser,  // is_collection
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // start tick, end tick, first_peak_tick, second_peak_tick, peak_count, zero pad
   output logic [pef_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   logic               push, pop;
   pef_pkg::pair_type  push_pair, head;
   pef_pkg::qstat_type qstat;

   assign csr_ready = !reset;

   pef_front #(
      .MAX_TICKS   (MAX_TICKS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_sample     (signed'(req_tdata[SAMPLE_BITS-1:0])),
      .in_collection (req_tuser),
      .in_wire_end   (req_tlast),
      .qstat         (qstat),
      .push          (push),
      .push_pair     (push_pair)
   );

   pef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pair (push_pair),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   pef_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/tb_pulse_extremum_finder_unit.sv -----
module tb_pulse_extremum_finder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W       = ((pef_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
   localparam int TICK_SAT    = pef_pkg::MAX_TICKS_DEF - 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TW          = pef_pkg::OUT_TICK_W;
   localparam int CW          = pef_pkg::CNT_W;

   localparam int START_LSB = 0;
   localparam int STOP_LSB  = START_LSB + TW;
   localparam int PEAK1_LSB = STOP_LSB + TW;
   localparam int PEAK2_LSB = PEAK1_LSB + TW;
   localparam int COUNT_LSB = PEAK2_LSB + TW;

   typedef struct {
      logic [TW-1:0] open_tick;
      logic [TW-1:0] stop_tick;
      logic [TW-1:0] first_peak;
      logic [TW-1:0] second_peak;
      logic [CW-1:0] peaks;
      logic          last_beat;
   } pulse_type;

   class pulse_scoreboard;
      int        thr_ind, thr_col;
      int        older, newer, tick, last_min;
      bit        pulse_live, held;
      int        open_start, open_peak;
      int        held_start, held_peak, held_stop, held_val;
      pulse_type awaited[$];
      pulse_type fresh[$];
      int        mismatches;

      function new();
         thr_ind    = 0;
         thr_col    = 0;
         mismatches = 0;
         reset_wire();
      endfunction

      function void reset_wire();
         older      = 0;
         newer      = 0;
         tick       = 0;
         last_min   = 0;
         pulse_live = 0;
         open_start = 0;
         open_peak  = 0;
         held       = 0;
         held_start = 0;
         held_peak  = 0;
         held_stop  = 0;
         held_val   = 0;
      endfunction

      function void write_threshold(logic [pef_pkg::CSR_IDX_W-1:0] idx,
                                    logic [pef_pkg::THR_W-1:0] val);
         if (idx == pef_pkg::CSR_THR_INDUCTION) thr_ind = val;
         else thr_col = val;
      endfunction

      function void add_pulse(int s, int e, int p1, int p2, logic [CW-1:0] cnt);
         pulse_type r;
         r.open_tick   = s[TW-1:0];
         r.stop_tick   = e[TW-1:0];
         r.first_peak  = p1[TW-1:0];
         r.second_peak = p2[TW-1:0];
         r.peaks       = cnt;
         r.last_beat   = 1'b0;
         fresh.insert(fresh.size(), r);
      endfunction

      function void flush_held();
         if (held) add_pulse(held_start, held_stop, held_peak, 0, pef_pkg::PEAKS_SINGLE);
         held = 0;
      endfunction

      // open pulse ends at tick e on sample v; pair with held one if adjacent and 2 * held_val > thr
      function void finish_pulse(int e, int v, int thr);
         pulse_live = 0;
         if (held && open_start == held_stop + 1 && 2 * held_val > thr) begin
            add_pulse(held_start, e, held_peak, open_peak, pef_pkg::PEAKS_MERGED);
            held = 0;
         end else begin
            flush_held();
            held       = 1;
            held_start = open_start;
            held_peak  = open_peak;
            held_stop  = e;
            held_val   = v;
         end
      endfunction

      function void note_sample(logic [REQ_W-1:0] raw, logic coll, logic wend);
         int cur, thr, t, c;
         cur = $signed(raw[pef_pkg::SAMPLE_BITS_DEF-1:0]);
         thr = coll ? thr_col : thr_ind;
         t   = tick;
         fresh.delete();
         if (t >= 2) begin
            c = t - 1;
            if (newer < older && newer < cur) begin
               if (pulse_live) begin
                  finish_pulse(c, newer, thr);
                  last_min = c + 1;
               end else begin
                  last_min = c;
               end
            end else if (newer > older && newer > cur && newer > thr) begin
               if (!pulse_live) begin
                  pulse_live = 1;
                  open_start = last_min;
                  open_peak  = c;
               end
            end
         end
         older = newer;
         newer = cur;
         if (tick < TICK_SAT) tick++;
         if (wend) begin
            if (pulse_live) finish_pulse(t, cur, thr);
            flush_held();
            reset_wire();
         end
         if (fresh.size() > 0) fresh[fresh.size()-1].last_beat = 1'b1;
         foreach (fresh[i]) awaited.insert(awaited.size(), fresh[i]);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 200) $error("%s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_pulse(logic [pef_pkg::RSP_TDATA_W-1:0] d, logic last);
         pulse_type w;
         if (awaited.size() == 0) begin
            mismatches++;
            $error("rsp beat with no pulse pending: tdata %h", d);
            return;
         end
         w = awaited.pop_front();
         check_field("start tick", w.open_tick, d[START_LSB +: TW]);
         check_field("end tick", w.stop_tick, d[STOP_LSB +: TW]);
         check_field("first_peak_tick", w.first_peak, d[PEAK1_LSB +: TW]);
         check_field("second_peak_tick", w.second_peak, d[PEAK2_LSB +: TW]);
         check_field("peak_count", w.peaks, d[COUNT_LSB +: CW]);
         check_field("last_for_input", w.last_beat, last);
      endfunction
   endclass

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [pef_pkg::CSR_IDX_W-1:0]     csr_index  = '0;
   logic [pef_pkg::THR_W-1:0]         csr_data   = '0;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [REQ_W-1:0]                  req_tdata  = '0;
   logic                              req_tuser  = 1'b0;
   logic                              req_tlast  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [pef_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                              rsp_tlast;

   pulse_scoreboard sb = new();
   bit allow_idle = 1'b0;
   int sent_items = 0;
   int cycles     = 0;
   int stall_left = 0;

   pulse_extremum_finder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
         if (csr_valid && csr_ready) sb.write_threshold(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_sample(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_pulse(rsp_tdata, rsp_tlast);
      end
   end

   // rsp back-pressure in bursts while allow_idle is set
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(int v, bit coll, bit wend);
      int gap;
      @(negedge clock);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v[REQ_W-1:0];
      req_tuser  <= coll;
      req_tlast  <= wend;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic send_run(int vals[$], bit coll, bit mixed);
      bit c;
      foreach (vals[i]) begin
         c = mixed ? bit'($urandom_range(0, 1)) : coll;
         send_sample(vals[i], c, i == vals.size() - 1);
      end
   endtask

   task automatic write_csr(logic [pef_pkg::CSR_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[pef_pkg::THR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_thresholds(int ti, int tc);
      drain();
      if ($urandom_range(0, 1)) begin
         write_csr(pef_pkg::CSR_THR_INDUCTION, ti);
         write_csr(pef_pkg::CSR_THR_COLLECTION, tc);
      end else begin
         write_csr(pef_pkg::CSR_THR_COLLECTION, tc);
         write_csr(pef_pkg::CSR_THR_INDUCTION, ti);
      end
   endtask

   function automatic void ramp(ref int q[$], input int a, input int b);
      int steps, v;
      steps = $urandom_range(1, 3);
      for (int k = 1; k <= steps; k++) begin
         v = a + (b - a) * k / steps;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         q.insert(q.size(), v);
      end
   endfunction

   // mostly hump trains around the plane threshold, some noise and tiny wires
   task automatic send_wire();
      int wave[$];
      bit coll, mixed;
      int thr, mode, prev, peak, valley;
      coll  = $urandom_range(0, 1);
      mixed = ($urandom_range(0, 9) == 0);
      thr   = coll ? sb.thr_col : sb.thr_ind;
      mode  = $urandom_range(0, 9);
      if (mode == 0) begin
         repeat ($urandom_range(1, 12))
            wave.insert(wave.size(), $urandom_range(0, 65535) - 32768);
      end else if (mode == 9) begin
         repeat ($urandom_range(1, 3))
            wave.insert(wave.size(), $urandom_range(0, 65535) - 32768);
      end else begin
         prev = $urandom_range(0, 200) - 100;
         wave.insert(wave.size(), prev);
         repeat ($urandom_range(1, 4)) begin
            peak = thr + $urandom_range(1, 3000);
            if ($urandom_range(0, 7) == 0) peak = thr;
            if (peak > 32767) peak = 32767;
            ramp(wave, prev, peak);
            case ($urandom_range(0, 3))
               0: valley = thr / 2 + 1 + $urandom_range(0, thr / 2);
               1: valley = $urandom_range(0, thr / 2);
               2: valley = -$urandom_range(0, 32768);
               default: valley = thr - $urandom_range(0, 100);
            endcase
            ramp(wave, peak, valley);
            if ($urandom_range(0, 5) == 0) wave.insert(wave.size(), wave[wave.size()-1]);
            prev = valley;
         end
         if ($urandom_range(0, 3) == 0) ramp(wave, prev, prev + $urandom_range(1, 500));
      end
      send_run(wave, coll, mixed);
   endtask

   initial begin
      int ti, tc, target;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // thresholds at reset value
      send_run({5, 10, 3, 0}, 0, 0);
      set_thresholds(100, 1000);
      send_run({32767}, 1, 0);
      send_run({-32768, 32767}, 0, 0);
      send_run({0, 200, 80, 300, 0, -10}, 0, 0);
      send_run({0, 200, 150, 150, 300, 0}, 0, 0);
      send_run({0, 200, 30, 300, 0}, 0, 0);
      send_run({0, 500, 0, 1500, 0, 1200}, 0, 1);

      allow_idle = 1'b1;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin ti = 0; tc = 0; end
            1: begin ti = 32767; tc = 32767; end
            2: begin ti = 0; tc = 32767; end
            3: begin ti = 32767; tc = 0; end
            default: begin
               ti = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(1, 2000);
               tc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(1, 2000);
            end
         endcase
         set_thresholds(ti, tc);
         target = sent_items + 72;
         while (sent_items < target) send_wire();
      end

      allow_idle = 1'b0;
      set_thresholds($urandom_range(1, 300), $urandom_range(0, 300));
      target = sent_items + 60;
      while (sent_items < target) send_wire();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
